>>> rtl/fbpa_pkg.sv
// Package for the fixed block pool allocator: widths, codes and payload types.
// Used by every module of the block; depends on nothing.
package fbpa_pkg;

  // Pool depth must be a power of two.
  localparam int MAX_BLOCKS = 1024;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

  localparam int ADDR_W     = 32;
  localparam int BSIZE_W    = 16;
  localparam int LIMIT_W    = 11;
  localparam int USED_W     = 11;
  localparam int PROD_W     = IDX_W + BSIZE_W;

  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  localparam int DIV_BITS   = 2;
  localparam int DIV_STEPS  = ADDR_W / DIV_BITS;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam int Q_DEPTH    = 2;
  localparam int QPTR_W     = $clog2(Q_DEPTH);
  localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic [BSIZE_W-1:0] BSIZE_RST = BSIZE_W'(64);
  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(1024);
  localparam logic [ADDR_W-1:0]  BASE_RST  = '0;

  typedef enum logic [1:0] {
    REG_BLOCK_SIZE   = 2'd0,
    REG_BLOCK_LIMIT  = 2'd1,
    REG_BASE_ADDRESS = 2'd2
  } reg_idx_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SIZE      = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_NULL      = 3'd3,
    ST_UNDERFLOW = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CMD_ALLOC,
    CMD_SIZE,
    CMD_NULL,
    CMD_FREE
  } cmd_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_ARD,
    BS_AADD,
    BS_DIV,
    BS_DONE
  } bst_t;

  typedef struct packed {
    op_t                opcode;
    logic [ADDR_W-1:0]  request_size;
    logic [ADDR_W-1:0]  free_address;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic [ADDR_W-1:0]  block_address;
    logic [USED_W-1:0]  used_count;
  } out_t;

  typedef struct packed {
    cmd_t               cls;
    logic [ADDR_W-1:0]  diff;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

>>> rtl/fbpa_front.sv
// Front end of the pool allocator: accepts request transactions and classifies them.
// Depends on fbpa_pkg; feeds fbpa_queue.
module fbpa_front (
  input  logic                         in_valid,
  output logic                         in_stall,
  input  fbpa_pkg::in_t                in_data,
  input  logic [fbpa_pkg::BSIZE_W-1:0] block_size,
  input  logic [fbpa_pkg::ADDR_W-1:0]  base_address,
  input  fbpa_pkg::qstat_t             q_stat,
  output logic                         push,
  output fbpa_pkg::qent_t              push_entry
);
  import fbpa_pkg::*;

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    push_entry.diff = in_data.free_address - base_address;
    unique case (in_data.opcode)
      OP_ALLOC: begin
        push_entry.cls = (in_data.request_size != ADDR_W'(block_size)) ? CMD_SIZE : CMD_ALLOC;
      end
      OP_FREE: begin
        push_entry.cls = (in_data.free_address == '0) ? CMD_NULL : CMD_FREE;
      end
    endcase
  end

endmodule

>>> rtl/fbpa_queue.sv
// Short command queue between the front end and the back end of the pool allocator.
// Depends on fbpa_pkg.
module fbpa_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fbpa_pkg::qent_t   push_entry,
  input  logic              pop,
  output fbpa_pkg::qent_t   head,
  output fbpa_pkg::qstat_t  q_stat
);
  import fbpa_pkg::*;

  qent_t              ent_r [Q_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  fill_r, fill_nxt;
  logic               do_push, do_pop;

  assign q_stat.full  = (fill_r == QCNT_W'(Q_DEPTH));
  assign q_stat.empty = (fill_r == '0);
  assign head         = ent_r[rd_ptr_r];
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

>>> rtl/fbpa_div.sv
// Iterative restoring divider of the pool allocator, two quotient bits per cycle.
// Depends on fbpa_pkg; used by fbpa_back to turn a freed address into a block index.
module fbpa_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [fbpa_pkg::ADDR_W-1:0]  dividend,
  input  logic [fbpa_pkg::BSIZE_W-1:0] divisor,
  output logic                         done,
  output logic [fbpa_pkg::IDX_W-1:0]   quotient
);
  import fbpa_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [STEP_W-1:0]   step_r;
  logic [BSIZE_W-1:0]  divisor_r;
  logic [BSIZE_W-1:0]  rem_r;
  logic [ADDR_W-1:0]   dq_r;
  logic [BSIZE_W-1:0]  rem_w;
  logic [ADDR_W-1:0]   dq_w;
  logic [BSIZE_W:0]    trial;
  logic                qbit;

  assign done     = done_r;
  assign quotient = dq_r[IDX_W-1:0];

  always_comb begin
    rem_w = rem_r;
    dq_w  = dq_r;
    trial = '0;
    qbit  = 1'b0;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial = {rem_w, dq_w[ADDR_W-1]};
      qbit  = (trial >= {1'b0, divisor_r});
      if (qbit) begin
        trial = trial - {1'b0, divisor_r};
      end
      rem_w = trial[BSIZE_W-1:0];
      dq_w  = {dq_w[ADDR_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      divisor_r <= divisor;
      rem_r     <= '0;
      dq_r      <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_w;
      dq_r  <= dq_w;
    end
  end

endmodule

>>> rtl/fbpa_back.sv
// Back end of the pool allocator: free index stack, in-use count and result register.
// Depends on fbpa_pkg; drives fbpa_div and pops fbpa_queue.
module fbpa_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fbpa_pkg::qstat_t             q_stat,
  input  fbpa_pkg::qent_t              q_head,
  output logic                         q_pop,
  input  logic [fbpa_pkg::BSIZE_W-1:0] block_size,
  input  logic [fbpa_pkg::LIMIT_W-1:0] block_limit,
  input  logic [fbpa_pkg::ADDR_W-1:0]  base_address,
  output logic                         div_start,
  input  logic                         div_done,
  input  logic [fbpa_pkg::IDX_W-1:0]   div_quot,
  output logic                         out_valid,
  input  logic                         out_stall,
  output fbpa_pkg::out_t               out_data
);
  import fbpa_pkg::*;

  logic [IDX_W-1:0]   mem_r [MAX_BLOCKS];
  logic [IDX_W-1:0]   rd_data_r;
  logic               mem_re, mem_we;
  logic [IDX_W-1:0]   mem_waddr, mem_wdata;

  bst_t               state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   wm_r, wm_nxt;
  logic               init_r, init_nxt;
  status_t            status_r, status_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;
  logic [CNT_W-1:0]   count_dec;
  logic [IDX_W-1:0]   alloc_idx;
  logic               exhausted;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign count_dec = count_r - CNT_W'(1);
  assign alloc_idx = init_r ? count_r[IDX_W-1:0] : rd_data_r;
  assign exhausted = (count_r >= CNT_W'(MAX_BLOCKS)) ||
                     (ADDR_W'(count_r) >= ADDR_W'(block_limit));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    wm_nxt        = wm_r;
    init_nxt      = init_r;
    status_nxt    = status_r;
    addr_nxt      = addr_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = count_dec[IDX_W-1:0];
    mem_wdata     = (block_size == '0) ? '0 : div_quot;
    div_start     = 1'b0;
    unique case (state_r)
      BS_IDLE: begin
        if (!q_stat.empty) begin
          q_pop    = 1'b1;
          addr_nxt = '0;
          unique case (q_head.cls)
            CMD_SIZE: begin
              status_nxt = ST_SIZE;
              state_nxt  = BS_DONE;
            end
            CMD_NULL: begin
              status_nxt = ST_NULL;
              state_nxt  = BS_DONE;
            end
            CMD_ALLOC: begin
              if (exhausted) begin
                status_nxt = ST_EXHAUSTED;
                state_nxt  = BS_DONE;
              end else begin
                mem_re    = 1'b1;
                init_nxt  = (count_r >= wm_r);
                state_nxt = BS_ARD;
              end
            end
            CMD_FREE: begin
              if (count_r == '0) begin
                status_nxt = ST_UNDERFLOW;
                state_nxt  = BS_DONE;
              end else begin
                div_start = 1'b1;
                state_nxt = BS_DIV;
              end
            end
          endcase
        end
      end
      BS_ARD: begin
        prod_nxt  = PROD_W'(alloc_idx) * PROD_W'(block_size);
        state_nxt = BS_AADD;
      end
      BS_AADD: begin
        addr_nxt   = base_address + ADDR_W'(prod_r);
        count_nxt  = count_r + CNT_W'(1);
        if (count_r >= wm_r) begin
          wm_nxt = count_r + CNT_W'(1);
        end
        status_nxt = ST_OK;
        state_nxt  = BS_DONE;
      end
      BS_DIV: begin
        if (div_done) begin
          mem_we     = 1'b1;
          count_nxt  = count_dec;
          status_nxt = ST_OK;
          state_nxt  = BS_DONE;
        end
      end
      BS_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: status_r, block_address: addr_r,
                            used_count: USED_W'(count_r)};
          state_nxt     = BS_IDLE;
        end
      end
      default: begin
        state_nxt = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      count_r     <= '0;
      wm_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      wm_r        <= wm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    init_r     <= init_nxt;
    status_r   <= status_nxt;
    addr_r     <= addr_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem_r[count_r[IDX_W-1:0]];
    end
  end

endmodule

>>> rtl/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: configuration registers and wiring.
// Depends on fbpa_pkg, fbpa_front, fbpa_queue, fbpa_div and fbpa_back.
//
//   Channel   Direction  Payload                                     Handshake
//   in_       request    opcode, request_size, free_address          valid / stall
//   out_      result     status, block_address, used_count           valid / stall
//   APB       config     block_size, block_limit, base_address      psel/penable
//
// An allocate goes from acceptance to result through the registered stack read, the index
// multiply and the base add. A free runs the divider at two quotient bits per cycle.
// Reset is synchronous; stack entries above the highest fill level read as their own index,
// so no clearing pass is needed. Up to two requests queue while the result is stalled.
module fixed_block_pool_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  fbpa_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output fbpa_pkg::out_t                out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fbpa_pkg::PADDR_W-1:0]  paddr,
  input  logic [fbpa_pkg::PDATA_W-1:0]  pwdata,
  output logic [fbpa_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import fbpa_pkg::*;

  logic [BSIZE_W-1:0]  block_size_r;
  logic [LIMIT_W-1:0]  block_limit_r;
  logic [ADDR_W-1:0]   base_r;
  reg_idx_t            reg_idx;
  logic                cfg_wr;

  logic                push, pop;
  qent_t               push_entry, q_head;
  qstat_t              q_stat;
  logic                div_start, div_done;
  logic [IDX_W-1:0]    div_quot;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_BLOCK_SIZE:   prdata = PDATA_W'(block_size_r);
      REG_BLOCK_LIMIT:  prdata = PDATA_W'(block_limit_r);
      REG_BASE_ADDRESS: prdata = PDATA_W'(base_r);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r  <= BSIZE_RST;
      block_limit_r <= LIMIT_RST;
      base_r        <= BASE_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BLOCK_SIZE:   block_size_r  <= pwdata[BSIZE_W-1:0];
        REG_BLOCK_LIMIT:  block_limit_r <= pwdata[LIMIT_W-1:0];
        REG_BASE_ADDRESS: base_r        <= pwdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  fbpa_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .block_size   (block_size_r),
    .base_address (base_r),
    .q_stat       (q_stat),
    .push         (push),
    .push_entry   (push_entry)
  );

  fbpa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (q_head),
    .q_stat     (q_stat)
  );

  fbpa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (q_head.diff),
    .divisor  (block_size_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  fbpa_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat       (q_stat),
    .q_head       (q_head),
    .q_pop        (pop),
    .block_size   (block_size_r),
    .block_limit  (block_limit_r),
    .base_address (base_r),
    .div_start    (div_start),
    .div_done     (div_done),
    .div_quot     (div_quot),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule

>>> rtl/fbpa_checker.sv
// Port-level checker for the fixed block pool allocator, bound to the top level.
// Depends on fbpa_pkg.
module fbpa_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            out_valid,
  input  logic            out_stall,
  input  fbpa_pkg::out_t  out_data
);
  import fbpa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.block_address == '0)
    else $error("failed transaction carries an address");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.used_count <= USED_W'(MAX_BLOCKS))
    else $error("used count beyond pool size");

  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_UNDERFLOW |-> out_data.used_count == '0)
    else $error("underflow reported with blocks in use");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);
